/* sv/ata_pio_read_sequencer_core_assert.svh */
// Assertion macros for the ATA PIO read sequencer; clocked on clk_i, muted while rst_ni is low.
`ifndef ATA_PIO_READ_SEQUENCER_CORE_ASSERT_SVH
`define ATA_PIO_READ_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define APR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("apr assertion failed");

// Next-cycle implication.
`define APR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("apr assertion failed");

`endif

/* sv/apr_pkg.sv */
// Types, constants and result builders shared by the ATA PIO read sequencer.
package apr_pkg;

  localparam int unsigned MaxResults     = 7;
  localparam int unsigned WordsPerSector = 256;
  localparam int unsigned CfgAddrWidth   = 3;

  localparam logic [19:0] PollLimitReset = 20'd200000;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdReply = 1'b1;

  // Register offsets from the channel base
  localparam logic [2:0] PortData    = 3'd0;
  localparam logic [2:0] PortSecCnt  = 3'd2;
  localparam logic [2:0] PortLbaLo   = 3'd3;
  localparam logic [2:0] PortLbaMid  = 3'd4;
  localparam logic [2:0] PortLbaHi   = 3'd5;
  localparam logic [2:0] PortDrvHead = 3'd6;
  localparam logic [2:0] PortCmdStat = 3'd7;

  // Status bit positions
  localparam int unsigned StBsyBit = 7;
  localparam int unsigned StDrqBit = 3;
  localparam int unsigned StErrBit = 0;

  localparam logic [7:0] DevHeadMaster  = 8'hE0;
  localparam logic [7:0] DevHeadSlave   = 8'hF0;
  localparam logic [7:0] AtaReadSectors = 8'h20;
  localparam logic [7:0] OneSector      = 8'h01;

  localparam logic [7:0] LastWord = 8'(WordsPerSector - 1);

  typedef enum logic [3:0] {
    PhIdle    = 4'b0001,
    PhWaitBsy = 4'b0010,
    PhWaitDrq = 4'b0100,
    PhRead    = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KindRead   = 2'd0,
    KindWrite  = 2'd1,
    KindStore  = 2'd2,
    KindFinish = 2'd3
  } kind_e;

  typedef struct packed {
    phase_e       phase;
    logic [27:0]  base_address;
    logic [7:0]   sector_index;
    logic [7:0]   sectors_total;
    logic         slave_selected;
    logic [19:0]  poll_count;
    logic [7:0]   word_index;
  } state_t;

  typedef struct packed {
    logic         cmd;
    logic         drive;
    logic [27:0]  start_lba;
    logic [7:0]   sector_count;
    logic [15:0]  read_data;
  } item_t;

  typedef struct packed {
    kind_e        kind;
    logic [2:0]   port;
    logic [7:0]   write_data;
    logic [15:0]  store_word;
    logic [16:0]  store_offset;
    logic         success;
  } res_t;

  typedef res_t [MaxResults-1:0] res_list_t;
  typedef logic [2:0] res_cnt_t;

  function automatic res_t mk_read(logic [2:0] port);
    res_t r;
    r      = '0;
    r.kind = KindRead;
    r.port = port;
    return r;
  endfunction

  function automatic res_t mk_write(logic [2:0] port, logic [7:0] data);
    res_t r;
    r            = '0;
    r.kind       = KindWrite;
    r.port       = port;
    r.write_data = data;
    return r;
  endfunction

  function automatic res_t mk_store(logic [15:0] word, logic [16:0] offset);
    res_t r;
    r              = '0;
    r.kind         = KindStore;
    r.store_word   = word;
    r.store_offset = offset;
    return r;
  endfunction

  function automatic res_t mk_finish(logic ok);
    res_t r;
    r         = '0;
    r.kind    = KindFinish;
    r.success = ok;
    return r;
  endfunction

endpackage

/* sv/apr_if.sv */
// Valid/ready stream interfaces for the sequencer's input items and result items.
interface apr_in_if;
  logic         valid;
  logic         ready;
  logic         cmd;
  logic         drive;
  logic [27:0]  start_lba;
  logic [7:0]   sector_count;
  logic [15:0]  read_data;

  modport source (output valid, cmd, drive, start_lba, sector_count, read_data, input ready);
  modport sink   (input valid, cmd, drive, start_lba, sector_count, read_data, output ready);
endinterface

interface apr_out_if;
  logic         valid;
  logic         ready;
  logic [1:0]   kind;
  logic [2:0]   port;
  logic [7:0]   write_data;
  logic [15:0]  store_word;
  logic [16:0]  store_offset;
  logic         success;
  logic         last;

  modport source (output valid, kind, port, write_data, store_word, store_offset, success,
                  last, input ready);
  modport sink   (input valid, kind, port, write_data, store_word, store_offset, success,
                  last, output ready);
endinterface

/* sv/apr_step.sv */
// Next-state and result-list logic for one item of the ATA PIO read sequencer.
module apr_step (
  input  apr_pkg::state_t    state_i,
  input  apr_pkg::item_t     item_i,
  input  logic [19:0]        poll_limit_i,
  output apr_pkg::state_t    state_o,
  output apr_pkg::res_list_t res_o,
  output apr_pkg::res_cnt_t  cnt_o
);

  logic [7:0]  status;
  logic [20:0] poll_inc;
  logic        poll_expired;
  logic [27:0] lba;
  logic [7:0]  dev_head;
  logic [7:0]  sector_inc;

  assign status       = item_i.read_data[7:0];
  assign poll_inc     = {1'b0, state_i.poll_count} + 21'd1;
  assign poll_expired = poll_inc >= {1'b0, poll_limit_i};
  assign lba          = state_i.base_address + {20'd0, state_i.sector_index};
  assign dev_head     = (state_i.slave_selected ? apr_pkg::DevHeadSlave : apr_pkg::DevHeadMaster)
                        | {4'd0, lba[27:24]};
  assign sector_inc   = state_i.sector_index + 8'd1;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    cnt_o   = '0;
    if (item_i.cmd == apr_pkg::CmdStart) begin
      state_o.slave_selected = item_i.drive;
      state_o.base_address   = item_i.start_lba;
      state_o.sectors_total  = item_i.sector_count;
      state_o.sector_index   = '0;
      state_o.word_index     = '0;
      state_o.poll_count     = '0;
      if (item_i.sector_count == 8'd0) begin
        state_o.phase = apr_pkg::PhIdle;
        res_o[0]      = apr_pkg::mk_finish(1'b0);
      end else begin
        state_o.phase = apr_pkg::PhWaitBsy;
        res_o[0]      = apr_pkg::mk_read(apr_pkg::PortCmdStat);
      end
      cnt_o = 3'd1;
    end else begin
      unique case (state_i.phase)
        apr_pkg::PhIdle: begin
          // drop stray replies
        end
        apr_pkg::PhWaitBsy: begin
          if (!status[apr_pkg::StBsyBit]) begin
            res_o[0] = apr_pkg::mk_write(apr_pkg::PortSecCnt, apr_pkg::OneSector);
            res_o[1] = apr_pkg::mk_write(apr_pkg::PortLbaLo, lba[7:0]);
            res_o[2] = apr_pkg::mk_write(apr_pkg::PortLbaMid, lba[15:8]);
            res_o[3] = apr_pkg::mk_write(apr_pkg::PortLbaHi, lba[23:16]);
            res_o[4] = apr_pkg::mk_write(apr_pkg::PortDrvHead, dev_head);
            res_o[5] = apr_pkg::mk_write(apr_pkg::PortCmdStat, apr_pkg::AtaReadSectors);
            res_o[6] = apr_pkg::mk_read(apr_pkg::PortCmdStat);
            cnt_o    = 3'd7;
            state_o.phase      = apr_pkg::PhWaitDrq;
            state_o.poll_count = '0;
          end else if (poll_expired) begin
            state_o.phase = apr_pkg::PhIdle;
            res_o[0]      = apr_pkg::mk_finish(1'b0);
            cnt_o         = 3'd1;
          end else begin
            state_o.poll_count = poll_inc[19:0];
            res_o[0]           = apr_pkg::mk_read(apr_pkg::PortCmdStat);
            cnt_o              = 3'd1;
          end
        end
        apr_pkg::PhWaitDrq: begin
          cnt_o = 3'd1;
          priority if (status[apr_pkg::StErrBit]) begin
            state_o.phase = apr_pkg::PhIdle;
            res_o[0]      = apr_pkg::mk_finish(1'b0);
          end else if (status[apr_pkg::StDrqBit]) begin
            state_o.phase      = apr_pkg::PhRead;
            state_o.word_index = '0;
            res_o[0]           = apr_pkg::mk_read(apr_pkg::PortData);
          end else if (!status[apr_pkg::StBsyBit] || poll_expired) begin
            state_o.phase = apr_pkg::PhIdle;
            res_o[0]      = apr_pkg::mk_finish(1'b0);
          end else begin
            state_o.poll_count = poll_inc[19:0];
            res_o[0]           = apr_pkg::mk_read(apr_pkg::PortCmdStat);
          end
        end
        apr_pkg::PhRead: begin
          res_o[0] = apr_pkg::mk_store(item_i.read_data,
                                       {state_i.sector_index, state_i.word_index, 1'b0});
          cnt_o    = 3'd2;
          if (state_i.word_index != apr_pkg::LastWord) begin
            state_o.word_index = state_i.word_index + 8'd1;
            res_o[1]           = apr_pkg::mk_read(apr_pkg::PortData);
          end else begin
            state_o.word_index   = '0;
            state_o.sector_index = sector_inc;
            if (sector_inc == state_i.sectors_total) begin
              state_o.phase = apr_pkg::PhIdle;
              res_o[1]      = apr_pkg::mk_finish(1'b1);
            end else begin
              state_o.phase      = apr_pkg::PhWaitBsy;
              state_o.poll_count = '0;
              res_o[1]           = apr_pkg::mk_read(apr_pkg::PortCmdStat);
            end
          end
        end
        default: begin
          state_o.phase = apr_pkg::PhIdle;
        end
      endcase
    end
  end

endmodule

/* sv/ata_pio_read_sequencer_core.sv */
// Top level of the ATA PIO LBA28 read sequencer: input stage, step logic, result buffer, APB.
//
//  channel | dir | handshake        | carries
//  --------+-----+------------------+-------------------------------------------------
//  in_i    | in  | valid/ready      | cmd, drive, start_lba, sector_count, read_data
//  out_o   | out | valid/ready      | kind, port, write_data, store_word, store_offset,
//          |     |                  | success, last
//  APB     | in  | psel/penable     | poll_limit at byte address 0
//
//  An accepted item waits in the input register; the step logic turns it combinationally
//  into 0 to 7 results, which load into the result buffer as the item moves on.
//  The buffer hands out one result per transfer, so single-result items flow at one per
//  cycle while out_o.ready stays high.
//  The next item is taken while the buffer still drains; it moves on in the cycle the
//  buffer's last result transfers.
//  Reset empties both stages, sets the phase to idle and poll_limit to 200000.
module ata_pio_read_sequencer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  apr_in_if.sink                            in_i,
  apr_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apr_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration register
  logic [19:0] poll_limit_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {12'd0, poll_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= apr_pkg::PollLimitReset;
    end else if (cfg_wr) begin
      poll_limit_q <= pwdata[19:0];
    end
  end

  // Input register
  logic            in_vld_q;
  apr_pkg::item_t  item_q;
  logic            advance;
  logic            in_fire;

  assign in_i.ready = !in_vld_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.cmd          <= in_i.cmd;
      item_q.drive        <= in_i.drive;
      item_q.start_lba    <= in_i.start_lba;
      item_q.sector_count <= in_i.sector_count;
      item_q.read_data    <= in_i.read_data;
    end
  end

  // Sequencer state and step logic
  apr_pkg::state_t    state_q;
  apr_pkg::state_t    state_d;
  apr_pkg::res_list_t step_res;
  apr_pkg::res_cnt_t  step_cnt;

  apr_step u_step (
    .state_i      (state_q),
    .item_i       (item_q),
    .poll_limit_i (poll_limit_q),
    .state_o      (state_d),
    .res_o        (step_res),
    .cnt_o        (step_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= apr_pkg::PhIdle;
      state_q.base_address   <= '0;
      state_q.sector_index   <= '0;
      state_q.sectors_total  <= '0;
      state_q.slave_selected <= 1'b0;
      state_q.poll_count     <= '0;
      state_q.word_index     <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result buffer: cnt_q results loaded at once, idx_q points at the one on offer
  apr_pkg::res_list_t res_q;
  apr_pkg::res_cnt_t  cnt_q;
  apr_pkg::res_cnt_t  idx_q;
  apr_pkg::res_t      cur;
  logic               out_vld;
  logic               out_last;
  logic               out_fire;

  assign out_vld  = cnt_q != 3'd0;
  assign out_last = idx_q == (cnt_q - 3'd1);
  assign out_fire = out_vld && out_o.ready;
  // Advance the held item once the buffer is empty or hands out its final result
  assign advance  = in_vld_q && (!out_vld || (out_fire && out_last));
  assign cur      = res_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (advance) begin
      cnt_q <= step_cnt;
      idx_q <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_o.valid        = out_vld;
  assign out_o.kind         = cur.kind;
  assign out_o.port         = cur.port;
  assign out_o.write_data   = cur.write_data;
  assign out_o.store_word   = cur.store_word;
  assign out_o.store_offset = cur.store_offset;
  assign out_o.success      = cur.success;
  assign out_o.last         = out_last;

  `include "ata_pio_read_sequencer_core_assert.svh"

  `APR_ASSERT_IMP(a_idx_in_range, out_vld, idx_q < cnt_q)
  `APR_ASSERT_NXT(a_drain_steps, out_fire && !out_last, out_vld && (idx_q == $past(idx_q) + 3'd1))
  `APR_ASSERT_IMP(a_finish_is_last, out_vld && (cur.kind == apr_pkg::KindFinish), out_last)
  `APR_ASSERT_NXT(a_item_held, in_vld_q && !advance, in_vld_q)

endmodule

/* dv/tb.sv */
// Self-checking testbench for the ATA PIO LBA28 read sequencer: random port replies, APB setup.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apr_pkg::*;

  // Register map: poll_limit is the only register, at byte address 0.
  localparam int unsigned RegPollLimit = 0;
  // Input stage plus step stage, with margin for the result buffer.
  localparam int unsigned SettleCycles = 8;
  // Watchdog bound on the whole run.
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned MaxPrinted   = 30;

  // One port-bus operation as seen on the result channel.
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  port;
    logic [7:0]  wr_byte;
    logic [15:0] word;
    logic [16:0] offset;
    logic        ok;
    logic        last;
  } port_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  apr_in_if  in_if();
  apr_out_if out_if();

  ata_pio_read_sequencer_core u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Items waiting for the driver, and port operations the block still owes us.
  item_t    pending_items[$];
  port_op_t expected_ops[$];

  // Sequencer state tracked at acceptance time (drives checking) and at planning
  // time (steers the stimulus toward meaningful replies).
  state_t      dut_st;
  logic [19:0] dut_limit;
  state_t      plan_st;
  logic [19:0] plan_limit;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned result_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("%0t ERROR: %s", $time, msg);
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequencer prediction
  // ------------------------------------------------------------------------

  function automatic void add_op(ref port_op_t q[$], input kind_e k, input logic [2:0] p,
                                 input logic [7:0] b, input logic [15:0] w,
                                 input logic [16:0] o, input logic ok);
    port_op_t op;
    op.kind    = k;
    op.port    = p;
    op.wr_byte = b;
    op.word    = w;
    op.offset  = o;
    op.ok      = ok;
    op.last    = 1'b0;
    q.push_back(op);
  endfunction

  // Count one more status read in a wait; give up once the limit is reached.
  // A limit of zero therefore acts as a limit of one.
  function automatic void poll_status_again(ref state_t s, input logic [19:0] limit,
                                            ref port_op_t q[$]);
    if (21'(s.poll_count) + 21'd1 >= 21'(limit)) begin
      s.phase = PhIdle;
      add_op(q, KindFinish, '0, '0, '0, '0, 1'b0);
    end else begin
      s.poll_count = s.poll_count + 20'd1;
      add_op(q, KindRead, PortCmdStat, '0, '0, '0, 1'b0);
    end
  endfunction

  // Advance the sequencer by one accepted item and append the operations it causes.
  function automatic void step_sequencer(ref state_t s, input logic [19:0] limit,
                                         input item_t it, ref port_op_t q[$]);
    int unsigned first;
    logic [7:0]  status;
    logic [27:0] lba;
    logic [16:0] off;
    port_op_t    tail;
    first  = q.size();
    status = it.read_data[7:0];
    if (it.cmd == CmdStart) begin
      // A start always wins, dropping whatever transfer was running.
      s.slave_selected = it.drive;
      s.base_address   = it.start_lba;
      s.sectors_total  = it.sector_count;
      s.sector_index   = '0;
      s.word_index     = '0;
      s.poll_count     = '0;
      if (it.sector_count == 8'd0) begin
        s.phase = PhIdle;
        add_op(q, KindFinish, '0, '0, '0, '0, 1'b0);
      end else begin
        s.phase = PhWaitBsy;
        add_op(q, KindRead, PortCmdStat, '0, '0, '0, 1'b0);
      end
    end else begin
      case (s.phase)
        PhWaitBsy: begin
          if (!status[StBsyBit]) begin
            // Issue READ SECTORS for the current sector; the LBA sum wraps at 28 bits.
            lba = s.base_address + 28'(s.sector_index);
            add_op(q, KindWrite, PortSecCnt, OneSector, '0, '0, 1'b0);
            add_op(q, KindWrite, PortLbaLo, lba[7:0], '0, '0, 1'b0);
            add_op(q, KindWrite, PortLbaMid, lba[15:8], '0, '0, 1'b0);
            add_op(q, KindWrite, PortLbaHi, lba[23:16], '0, '0, 1'b0);
            add_op(q, KindWrite, PortDrvHead,
                   (s.slave_selected ? DevHeadSlave : DevHeadMaster) | {4'h0, lba[27:24]},
                   '0, '0, 1'b0);
            add_op(q, KindWrite, PortCmdStat, AtaReadSectors, '0, '0, 1'b0);
            s.phase      = PhWaitDrq;
            s.poll_count = '0;
            add_op(q, KindRead, PortCmdStat, '0, '0, '0, 1'b0);
          end else begin
            poll_status_again(s, limit, q);
          end
        end
        PhWaitDrq: begin
          // ERR takes precedence, then DRQ; BSY clear without DRQ is a failure.
          if (status[StErrBit]) begin
            s.phase = PhIdle;
            add_op(q, KindFinish, '0, '0, '0, '0, 1'b0);
          end else if (status[StDrqBit]) begin
            s.phase      = PhRead;
            s.word_index = '0;
            add_op(q, KindRead, PortData, '0, '0, '0, 1'b0);
          end else if (!status[StBsyBit]) begin
            s.phase = PhIdle;
            add_op(q, KindFinish, '0, '0, '0, '0, 1'b0);
          end else begin
            poll_status_again(s, limit, q);
          end
        end
        PhRead: begin
          off = {s.sector_index, 9'd0} + 17'({s.word_index, 1'b0});
          add_op(q, KindStore, '0, '0, it.read_data, off, 1'b0);
          if (s.word_index != LastWord) begin
            s.word_index = s.word_index + 8'd1;
            add_op(q, KindRead, PortData, '0, '0, '0, 1'b0);
          end else begin
            s.word_index   = '0;
            s.sector_index = s.sector_index + 8'd1;
            if (s.sector_index == s.sectors_total) begin
              s.phase = PhIdle;
              add_op(q, KindFinish, '0, '0, '0, '0, 1'b1);
            end else begin
              s.phase      = PhWaitBsy;
              s.poll_count = '0;
              add_op(q, KindRead, PortCmdStat, '0, '0, '0, 1'b0);
            end
          end
        end
        default: begin
          // Reply while idle: ignored, nothing comes out.
        end
      endcase
    end
    // Mark the final operation caused by this item.
    if (q.size() != first) begin
      tail      = q.pop_back();
      tail.last = 1'b1;
      q.push_back(tail);
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus planning
  // ------------------------------------------------------------------------

  // Fill every field with noise; callers overwrite what matters.
  function automatic item_t rand_item();
    item_t it;
    it.cmd          = 1'($urandom);
    it.drive        = 1'($urandom);
    it.start_lba    = 28'($urandom);
    it.sector_count = 8'($urandom);
    it.read_data    = 16'($urandom);
    return it;
  endfunction

  // Queue one item and advance the planning copy; return 0 for items the block ignores.
  function automatic bit plan_item(input item_t it);
    port_op_t scratch[$];
    bit       ignored;
    ignored = (it.cmd == CmdReply) && (plan_st.phase == PhIdle);
    pending_items.push_back(it);
    step_sequencer(plan_st, plan_limit, it, scratch);
    return !ignored;
  endfunction

  task automatic put_start(input logic drv, input logic [27:0] lba, input logic [7:0] cnt);
    item_t it;
    it              = rand_item();
    it.cmd          = CmdStart;
    it.drive        = drv;
    it.start_lba    = lba;
    it.sector_count = cnt;
    void'(plan_item(it));
  endtask

  task automatic put_reply(input logic [15:0] data);
    item_t it;
    it           = rand_item();
    it.cmd       = CmdReply;
    it.read_data = data;
    void'(plan_item(it));
  endtask

  // Mostly well-formed transfers with random content; busy_pct sets how often a
  // status poll still sees BSY, which is what drives poll timeouts.
  task automatic run_traffic(input int unsigned budget, input int unsigned busy_pct);
    item_t       it;
    int unsigned made;
    int unsigned pick;
    bit          want_start;
    made = 0;
    while (made < budget) begin
      it = rand_item();
      if (plan_st.phase == PhIdle) begin
        want_start = ($urandom_range(0, 9) != 0);
      end else begin
        want_start = ($urandom_range(0, 299) == 0);
      end
      if (want_start) begin
        it.cmd = CmdStart;
        pick   = $urandom_range(0, 19);
        if (pick == 0) begin
          it.sector_count = 8'd0;
        end else if (pick == 1) begin
          it.sector_count = 8'd255;
        end else if (pick == 2) begin
          it.sector_count = 8'($urandom_range(0, 255));
        end else begin
          it.sector_count = 8'($urandom_range(1, 3));
        end
        // Land near the top of the LBA space now and then to exercise the wrap.
        if ($urandom_range(0, 3) == 0) begin
          it.start_lba = 28'hFFF_FFFF - 28'($urandom_range(0, 2));
        end
      end else begin
        it.cmd = CmdReply;
        case (plan_st.phase)
          PhWaitBsy: begin
            it.read_data[StBsyBit] = ($urandom_range(0, 99) < busy_pct);
          end
          PhWaitDrq: begin
            pick = $urandom_range(0, 99);
            it.read_data[StErrBit] = 1'b0;
            it.read_data[StDrqBit] = 1'b0;
            it.read_data[StBsyBit] = 1'b1;
            if (pick < busy_pct) begin
              // still busy, keep polling
            end else if (pick < busy_pct + 8) begin
              it.read_data[StErrBit] = 1'b1;
              it.read_data[StDrqBit] = 1'($urandom);
              it.read_data[StBsyBit] = 1'($urandom);
            end else if (pick < busy_pct + 16) begin
              it.read_data[StBsyBit] = 1'b0;
            end else begin
              it.read_data[StDrqBit] = 1'b1;
              it.read_data[StBsyBit] = 1'($urandom);
            end
          end
          default: begin
            // data words and stray replies keep their random value
          end
        endcase
      end
      made += plan_item(it);
    end
  endtask

  // ------------------------------------------------------------------------
  // Handshake pacing
  // ------------------------------------------------------------------------

  // Flip between calm stretches (no waiting) and bursty ones (a random wait drawn per transfer).
  function automatic int unsigned draw_wait(ref bit calm);
    if ($urandom_range(0, 39) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // ------------------------------------------------------------------------
  // Driver: present queued items on the input channel
  // ------------------------------------------------------------------------

  item_t       in_flight;
  int unsigned in_hold = 0;
  bit          in_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      // Predict on the transfer itself, so every result finds its expectation queued.
      if (in_if.valid && in_if.ready) begin
        step_sequencer(dut_st, dut_limit, in_flight, expected_ops);
        in_hold = draw_wait(in_calm);
      end
      // Hold the item while the block stalls; otherwise advance or idle.
      if (!in_if.valid || in_if.ready) begin
        if (in_hold != 0) begin
          in_hold--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_flight = pending_items.pop_front();
          in_if.valid        <= 1'b1;
          in_if.cmd          <= in_flight.cmd;
          in_if.drive        <= in_flight.drive;
          in_if.start_lba    <= in_flight.start_lba;
          in_if.sector_count <= in_flight.sector_count;
          in_if.read_data    <= in_flight.read_data;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expectation
  // ------------------------------------------------------------------------

  int unsigned out_hold = 0;
  bit          out_calm = 1'b0;

  always @(posedge clk) begin
    port_op_t got;
    port_op_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.kind    = kind_e'(out_if.kind);
        got.port    = out_if.port;
        got.wr_byte = out_if.write_data;
        got.word    = out_if.store_word;
        got.offset  = out_if.store_offset;
        got.ok      = out_if.success;
        got.last    = out_if.last;
        if (expected_ops.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = expected_ops.pop_front();
          if (got !== want) begin
            flag_error($sformatf({"result %0d got kind %0d port %0d byte %02h word %04h ",
                                  "off %05h ok %0b last %0b, want %0d %0d %02h %04h %05h ",
                                  "%0b %0b"}, result_count,
                                 got.kind, got.port, got.wr_byte, got.word, got.offset,
                                 got.ok, got.last, want.kind, want.port, want.wr_byte,
                                 want.word, want.offset, want.ok, want.last));
          end
        end
        result_count++;
        out_hold = draw_wait(out_calm);
      end else if (out_hold != 0) begin
        out_hold--;
      end
      // Drop ready for the drawn stall, then raise it and keep it up.
      out_if.ready <= (out_hold == 0);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Configuration and phase control
  // ------------------------------------------------------------------------

  // Wait until every item is taken and every result is back, then let the
  // pipeline drain items that produce nothing. Sample away from the rising
  // edge so the driver's updates of that edge are already visible.
  task automatic settle();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_if.valid || expected_ops.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write poll_limit over APB, then read it back.
  task automatic program_poll_limit(input logic [19:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrWidth'(4 * RegPollLimit);
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dut_limit  = value;
    plan_limit = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(value)) begin
      flag_error($sformatf("poll_limit read back %08h, wrote %05h", prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    // Known values on every input from time zero.
    in_if.valid        = 1'b0;
    in_if.cmd          = CmdStart;
    in_if.drive        = 1'b0;
    in_if.start_lba    = '0;
    in_if.sector_count = '0;
    in_if.read_data    = '0;
    out_if.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;

    dut_st       = '0;
    dut_st.phase = PhIdle;
    dut_limit    = PollLimitReset;
    plan_st      = dut_st;
    plan_limit   = PollLimitReset;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset limit.
    put_reply(16'h1234);                    // reply while idle: ignored
    put_start(1'b0, 28'h000_0000, 8'd0);    // zero sector count fails at once
    put_start(1'b1, 28'hFFF_FFFF, 8'd2);    // slave, top LBA
    put_reply(16'h0080);                    // BSY: poll again
    put_reply(16'h0000);                    // BSY clear: command sequence
    put_reply(16'h0080);                    // DRQ wait, still busy
    put_reply(16'h0008);                    // DRQ: start reading data
    put_reply(16'hFFFF);
    put_reply(16'h0000);
    put_start(1'b0, 28'h000_0001, 8'd1);    // start while busy drops the transfer
    put_reply(16'h007F);                    // BSY clear, other status bits set
    put_reply(16'h0009);                    // ERR beats DRQ
    put_start(1'b1, 28'h0AB_CDEF, 8'd255);
    put_reply(16'h0000);
    put_reply(16'h0000);                    // BSY clear without DRQ fails
    put_start(1'b0, 28'h800_0000, 8'd3);
    put_reply(16'h00FF);
    put_reply(16'h0000);
    put_reply(16'hFF81);                    // ERR with BSY still set fails
    run_traffic(120, 20);
    settle();

    // Sweep poll_limit through small, extreme and random settings.
    program_poll_limit(20'd3);
    run_traffic(50, 50);
    settle();
    program_poll_limit(20'd1);
    run_traffic(30, 40);
    settle();
    program_poll_limit(20'd0);              // zero acts as a limit of one
    run_traffic(20, 40);
    settle();
    program_poll_limit(20'hFFFFF);
    run_traffic(150, 20);
    settle();
    program_poll_limit(20'($urandom_range(2, 6)));
    run_traffic(80, 50);
    settle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
